@@ rtl/chip8_interpreter_core_defines.svh @@
// assertion macros shared by the interpreter core modules
`ifndef CHIP8_INTERPRETER_CORE_DEFINES_SVH
`define CHIP8_INTERPRETER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define C8I_ASSERT_IMPL(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");
`define C8I_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define C8I_ASSERT_IMPL(lbl, clk, rst, pre, post)
`define C8I_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

@@ rtl/c8i_pkg.sv @@
// types, codes and constants of the interpreter core
`default_nettype none
package c8i_pkg;

   localparam int MEM_BYTES = 4096;
   localparam int MEM_AW    = 12;
   localparam int SCREEN_W  = 64;
   localparam int SCREEN_H  = 32;
   localparam int FONT_LEN  = 80;

   localparam logic [11:0] START_PC = 12'h200;

   localparam logic [2:0] REQ_LOAD = 3'd0;
   localparam logic [2:0] REQ_STEP = 3'd1;
   localparam logic [2:0] REQ_TICK = 3'd2;
   localparam logic [2:0] REQ_KEY  = 3'd3;
   localparam logic [2:0] REQ_ROW  = 3'd4;
   localparam logic [2:0] REQ_READ = 3'd5;

   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_UNKNOWN = 2'd1;
   localparam logic [1:0] STS_HALTED  = 2'd2;
   localparam logic [1:0] STS_FAULT   = 2'd3;

   localparam logic [11:0] NNN_CLS = 12'h0E0;
   localparam logic [11:0] NNN_RET = 12'h0EE;
   localparam logic [7:0]  KK_SKP  = 8'h9E;
   localparam logic [7:0]  KK_SKNP = 8'hA1;
   localparam logic [7:0]  KK_GDT  = 8'h07;
   localparam logic [7:0]  KK_SDT  = 8'h15;
   localparam logic [7:0]  KK_SST  = 8'h18;
   localparam logic [7:0]  KK_ADDI = 8'h1E;
   localparam logic [7:0]  KK_FONT = 8'h29;
   localparam logic [7:0]  KK_BCD  = 8'h33;
   localparam logic [7:0]  KK_STOR = 8'h55;
   localparam logic [7:0]  KK_LOAD = 8'h65;

   localparam logic [7:0] FONT [FONT_LEN] = '{
      8'hf0,8'h90,8'h90,8'h90,8'hf0, 8'h20,8'h60,8'h20,8'h20,8'h70,
      8'hf0,8'h10,8'hf0,8'h80,8'hf0, 8'hf0,8'h10,8'hf0,8'h10,8'hf0,
      8'h90,8'h90,8'hf0,8'h10,8'h10, 8'hf0,8'h80,8'hf0,8'h10,8'hf0,
      8'hf0,8'h80,8'hf0,8'h90,8'hf0, 8'hf0,8'h10,8'h20,8'h40,8'h40,
      8'hf0,8'h90,8'hf0,8'h90,8'hf0, 8'hf0,8'h90,8'hf0,8'h10,8'hf0,
      8'hf0,8'h90,8'hf0,8'h90,8'h90, 8'he0,8'h90,8'he0,8'h90,8'he0,
      8'hf0,8'h80,8'h80,8'h80,8'hf0, 8'he0,8'h90,8'h90,8'h90,8'he0,
      8'hf0,8'h80,8'hf0,8'h80,8'hf0, 8'hf0,8'h80,8'hf0,8'h80,8'h80
   };

   function automatic logic [7:0] font_byte(input logic [11:0] a);
      logic [7:0] b;
      b = 8'h00;
      if (a < 12'(FONT_LEN)) b = FONT[a[6:0]];
      return b;
   endfunction

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_TICK, ST_KEY, ST_ROW, ST_RD_ADDR, ST_RD_CAP,
      ST_REFUSE, ST_FETCH_HI, ST_FETCH_LO, ST_FETCH_OP, ST_READ_VY, ST_EXEC,
      ST_BCD, ST_STORE, ST_LV_ADDR, ST_LV_CAP, ST_DRAW_ADDR, ST_DRAW_ROW, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      DP_IDLE, DP_CLEAR, DP_CAPTURE, DP_LOAD, DP_TICK, DP_KEY, DP_ROW, DP_RD_ADDR,
      DP_RD_CAP, DP_REFUSE, DP_FETCH_HI, DP_FETCH_LO, DP_FETCH_OP, DP_READ_VY,
      DP_EXEC, DP_FAULT, DP_BCD, DP_STORE, DP_LV_ADDR, DP_LV_CAP, DP_DRAW_ADDR,
      DP_DRAW_ROW, DP_DRAW_END, DP_ISSUE
   } dp_op_type;

   typedef enum logic [2:0] {
      CLS_SIMPLE, CLS_UNKNOWN, CLS_FAULT, CLS_DRAW, CLS_BCD, CLS_STORE, CLS_LOADV
   } cls_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic    clear_done;
      logic    halted;
      cls_type cls;
      logic    bcd_last;
      logic    xfer_last;
      logic    draw_more;
   } dp_status_type;

   typedef struct packed {
      logic [4:0]  row_index;
      logic [7:0]  random_byte;
      logic        key_down;
      logic [3:0]  key_index;
      logic [7:0]  data_byte;
      logic [11:0] addr;
   } req_item_type;

endpackage
`default_nettype wire

@@ rtl/c8i_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module c8i_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ rtl/c8i_datapath.sv @@
// interpreter registers, memory, framebuffer and instruction execution
`default_nettype none
`include "chip8_interpreter_core_defines.svh"
module c8i_datapath import c8i_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output dp_status_type      dp_sts,
   input  wire req_item_type  req_item,
   input  wire logic          csr_we,
   input  wire logic [11:0]   csr_wdata,
   output logic [1:0]         rsp_status,
   output logic [11:0]        rsp_pc,
   output logic [7:0]         rsp_read_byte,
   output logic [63:0]        rsp_screen_row,
   output logic               rsp_sound_on
);
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int SIW = $clog2(STACK_DEPTH);

   req_item_type req_ff;
   logic [11:0]  start_ff, start_in;
   logic [11:0]  pc_ff, pc_in;
   logic [15:0]  idx_ff, idx_in;
   logic [SPW-1:0] sp_ff, sp_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         hit_ff, hit_in;
   logic         halted_ff, halted_in;
   logic [1:0]   sts_ff, sts_in;
   logic [7:0]   delay_ff, delay_in, sound_ff, sound_in;
   logic [7:0]   rbyte_ff, rbyte_in;
   logic [63:0]  row_ff, row_in;
   logic [11:0]  clr_ff, clr_in;
   logic [7:0]   op_hi_ff, op_lo_ff, vx_ff, vy_ff;
   logic [7:0]   v_ff [16];
   logic [11:0]  stk_ff [STACK_DEPTH];
   logic [15:0]  key_ff;
   logic [63:0]  frame_ff [SCREEN_H];

   logic         mem_we;
   logic [11:0]  mem_waddr, mem_raddr;
   logic [7:0]   mem_wdata, mem_rdata;

   logic         va_we, vf_we, stk_we, key_we, frm_clear, frm_we;
   logic [3:0]   va_sel;
   logic [7:0]   va_val, vf_val;

   logic [3:0]   x, y, n;
   logic [7:0]   kk;
   logic [11:0]  nnn, pc2, pc4, mem_ofs;
   cls_type      cls;
   logic [SPW-1:0] sp_dec;
   logic [SIW-1:0] push_idx, ret_idx;
   logic [8:0]   sum9, ysum;
   logic [7:0]   alu_val;
   logic         alu_flag, alu_flag_we;
   logic [1:0]   hund;
   logic [7:0]   rem;
   logic [14:0]  tens_prod;
   logic [3:0]   tens, ones;
   logic [7:0]   digit;
   logic [63:0]  sprite_bits;
   logic [4:0]   row_sel;

   c8i_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign x   = op_hi_ff[3:0];
   assign y   = op_lo_ff[7:4];
   assign n   = op_lo_ff[3:0];
   assign kk  = op_lo_ff;
   assign nnn = {op_hi_ff[3:0], op_lo_ff};
   assign pc2 = pc_ff + 12'd2;
   assign pc4 = pc_ff + 12'd4;
   assign mem_ofs  = idx_ff[11:0] + {7'b0, cnt_ff};
   assign sp_dec   = sp_ff - SPW'(1);
   assign push_idx = sp_ff[SIW-1:0];
   assign ret_idx  = sp_dec[SIW-1:0];

   // decode class
   always_comb begin
      cls = CLS_SIMPLE;
      unique case (op_hi_ff[7:4])
         4'h0: begin
            if (nnn == NNN_CLS) cls = CLS_SIMPLE;
            else if (nnn == NNN_RET) cls = (sp_ff == '0) ? CLS_FAULT : CLS_SIMPLE;
            else cls = CLS_UNKNOWN;
         end
         4'h2: cls = (sp_ff == SPW'(STACK_DEPTH)) ? CLS_FAULT : CLS_SIMPLE;
         4'h8: cls = (n inside {4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE})
                     ? CLS_SIMPLE : CLS_UNKNOWN;
         4'hD: cls = CLS_DRAW;
         4'hE: cls = (kk == KK_SKP || kk == KK_SKNP) ? CLS_SIMPLE : CLS_UNKNOWN;
         4'hF: begin
            unique case (kk) inside
               KK_GDT, KK_SDT, KK_SST, KK_ADDI, KK_FONT: cls = CLS_SIMPLE;
               KK_BCD:  cls = CLS_BCD;
               KK_STOR: cls = CLS_STORE;
               KK_LOAD: cls = CLS_LOADV;
               default: cls = CLS_UNKNOWN;
            endcase
         end
         default: cls = CLS_SIMPLE;
      endcase
   end

   // 8xyn alu
   always_comb begin
      sum9        = {1'b0, vx_ff} + {1'b0, vy_ff};
      alu_val     = vy_ff;
      alu_flag    = 1'b0;
      alu_flag_we = 1'b0;
      case (n)
         4'h1: alu_val = vx_ff | vy_ff;
         4'h2: alu_val = vx_ff & vy_ff;
         4'h3: alu_val = vx_ff ^ vy_ff;
         4'h4: begin alu_val = sum9[7:0]; alu_flag = sum9[8]; alu_flag_we = 1'b1; end
         4'h5: begin
            alu_val = vx_ff - vy_ff; alu_flag = (vx_ff >= vy_ff); alu_flag_we = 1'b1;
         end
         4'h6: begin alu_val = vx_ff >> 1; alu_flag = vx_ff[0]; alu_flag_we = 1'b1; end
         4'h7: begin
            alu_val = vy_ff - vx_ff; alu_flag = (vy_ff >= vx_ff); alu_flag_we = 1'b1;
         end
         4'hE: begin alu_val = vx_ff << 1; alu_flag = vx_ff[7]; alu_flag_we = 1'b1; end
         default: alu_val = vy_ff;
      endcase
   end

   // decimal digits of vx
   always_comb begin
      if (vx_ff >= 8'd200) begin hund = 2'd2; rem = vx_ff - 8'd200; end
      else if (vx_ff >= 8'd100) begin hund = 2'd1; rem = vx_ff - 8'd100; end
      else begin hund = 2'd0; rem = vx_ff; end
      tens_prod = {8'b0, rem[6:0]} * 15'd205;
      tens      = tens_prod[14:11];
      ones      = 4'(rem - {4'b0, tens} * 8'd10);
      case (cnt_ff[1:0])
         2'd0:    digit = {6'b0, hund};
         2'd1:    digit = {4'b0, tens};
         default: digit = {4'b0, ones};
      endcase
   end

   assign sprite_bits = {mem_rdata, 56'b0} >> vx_ff[5:0];
   assign ysum        = {1'b0, vy_ff} + {4'b0, cnt_ff};
   assign row_sel     = ysum[4:0];

   assign dp_sts.clear_done = (clr_ff == 12'(MEM_BYTES - 1));
   assign dp_sts.halted     = halted_ff;
   assign dp_sts.cls        = cls;
   assign dp_sts.bcd_last   = (cnt_ff == 5'd2);
   assign dp_sts.xfer_last  = (cnt_ff == {1'b0, x});
   assign dp_sts.draw_more  = (cnt_ff < {1'b0, n}) && (vx_ff < 8'(SCREEN_W))
                              && (ysum < 9'(SCREEN_H));

   always_comb begin
      start_in  = csr_we ? csr_wdata : start_ff;
      if (reset) start_in = START_PC;
      pc_in     = pc_ff;
      idx_in    = idx_ff;
      sp_in     = sp_ff;
      cnt_in    = cnt_ff;
      hit_in    = hit_ff;
      halted_in = halted_ff;
      sts_in    = sts_ff;
      delay_in  = delay_ff;
      sound_in  = sound_ff;
      rbyte_in  = rbyte_ff;
      row_in    = row_ff;
      clr_in    = clr_ff;
      mem_we    = 1'b0;
      mem_waddr = pc_ff;
      mem_wdata = 8'h00;
      mem_raddr = pc_ff;
      va_we     = 1'b0;
      va_sel    = x;
      va_val    = 8'h00;
      vf_we     = 1'b0;
      vf_val    = 8'h00;
      stk_we    = 1'b0;
      key_we    = 1'b0;
      frm_clear = 1'b0;
      frm_we    = 1'b0;
      unique case (cmd.op)
         DP_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = font_byte(clr_ff);
            clr_in    = clr_ff + 12'd1;
         end
         DP_CAPTURE: begin sts_in = STS_OK; rbyte_in = 8'h00; row_in = 64'h0; end
         DP_LOAD: begin
            mem_we = 1'b1; mem_waddr = req_ff.addr; mem_wdata = req_ff.data_byte;
         end
         DP_TICK: begin
            if (delay_ff != 8'h00) delay_in = delay_ff - 8'd1;
            if (sound_ff != 8'h00) sound_in = sound_ff - 8'd1;
         end
         DP_KEY:      key_we = 1'b1;
         DP_ROW:      row_in = frame_ff[req_ff.row_index];
         DP_RD_ADDR:  mem_raddr = req_ff.addr;
         DP_RD_CAP:   rbyte_in = mem_rdata;
         DP_REFUSE:   sts_in = STS_HALTED;
         DP_FETCH_HI: mem_raddr = pc_ff;
         DP_FETCH_LO: mem_raddr = pc_ff + 12'd1;
         DP_EXEC: begin
            cnt_in = 5'd0;
            hit_in = 1'b0;
            if (cls == CLS_SIMPLE) begin
               pc_in = pc2;
               unique case (op_hi_ff[7:4])
                  4'h0: begin
                     if (nnn == NNN_CLS) frm_clear = 1'b1;
                     else begin pc_in = stk_ff[ret_idx]; sp_in = sp_dec; end
                  end
                  4'h1: pc_in = nnn;
                  4'h2: begin stk_we = 1'b1; sp_in = sp_ff + SPW'(1); pc_in = nnn; end
                  4'h3: if (vx_ff == kk) pc_in = pc4;
                  4'h4: if (vx_ff != kk) pc_in = pc4;
                  4'h5: if (vx_ff == vy_ff) pc_in = pc4;
                  4'h6: begin va_we = 1'b1; va_val = kk; end
                  4'h7: begin va_we = 1'b1; va_val = vx_ff + kk; end
                  4'h8: begin
                     va_we = 1'b1; va_val = alu_val;
                     vf_we = alu_flag_we; vf_val = {7'b0, alu_flag};
                  end
                  4'h9: if (vx_ff != vy_ff) pc_in = pc4;
                  4'hA: idx_in = {4'b0, nnn};
                  4'hB: pc_in = {4'b0, v_ff[0]} + nnn;
                  4'hC: begin va_we = 1'b1; va_val = req_ff.random_byte & kk; end
                  4'hE: begin
                     if ((kk == KK_SKP) == key_ff[vx_ff[3:0]]) pc_in = pc4;
                  end
                  4'hF: begin
                     case (kk)
                        KK_GDT:  begin va_we = 1'b1; va_val = delay_ff; end
                        KK_SDT:  delay_in = vx_ff;
                        KK_SST:  sound_in = vx_ff;
                        KK_ADDI: idx_in = idx_ff + {8'b0, vx_ff};
                        default: idx_in = {12'b0, vx_ff[3:0]} * 16'd5;
                     endcase
                  end
                  default: pc_in = pc2;
               endcase
            end
         end
         DP_FAULT: begin
            halted_in = 1'b1;
            sts_in    = (cls == CLS_UNKNOWN) ? STS_UNKNOWN : STS_FAULT;
         end
         DP_BCD: begin
            mem_we = 1'b1; mem_waddr = mem_ofs; mem_wdata = digit;
            cnt_in = cnt_ff + 5'd1;
            if (dp_sts.bcd_last) pc_in = pc2;
         end
         DP_STORE: begin
            mem_we = 1'b1; mem_waddr = mem_ofs; mem_wdata = v_ff[cnt_ff[3:0]];
            cnt_in = cnt_ff + 5'd1;
            if (dp_sts.xfer_last) pc_in = pc2;
         end
         DP_LV_ADDR: mem_raddr = mem_ofs;
         DP_LV_CAP: begin
            va_we = 1'b1; va_sel = cnt_ff[3:0]; va_val = mem_rdata;
            cnt_in = cnt_ff + 5'd1;
            if (dp_sts.xfer_last) pc_in = pc2;
         end
         DP_DRAW_ADDR: mem_raddr = mem_ofs;
         DP_DRAW_ROW: begin
            frm_we = 1'b1;
            hit_in = hit_ff | (|(frame_ff[row_sel] & sprite_bits));
            cnt_in = cnt_ff + 5'd1;
         end
         DP_DRAW_END: begin
            vf_we = 1'b1; vf_val = {7'b0, hit_ff}; pc_in = pc2;
         end
         default: pc_in = pc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      if (reset) begin
         pc_ff     <= start_in;
         idx_ff    <= '0;
         sp_ff     <= '0;
         halted_ff <= 1'b0;
         delay_ff  <= '0;
         sound_ff  <= '0;
         clr_ff    <= '0;
         key_ff    <= '0;
         for (int i = 0; i < 16; i++) v_ff[i] <= '0;
         for (int i = 0; i < SCREEN_H; i++) frame_ff[i] <= '0;
      end else begin
         pc_ff     <= pc_in;
         idx_ff    <= idx_in;
         sp_ff     <= sp_in;
         halted_ff <= halted_in;
         delay_ff  <= delay_in;
         sound_ff  <= sound_in;
         clr_ff    <= clr_in;
         if (key_we) key_ff[req_ff.key_index] <= req_ff.key_down;
         // flag write wins over a result written to vf
         if (va_we && !(vf_we && va_sel == 4'hF)) v_ff[va_sel] <= va_val;
         if (vf_we) v_ff[15] <= vf_val;
         if (frm_clear) begin
            for (int i = 0; i < SCREEN_H; i++) frame_ff[i] <= '0;
         end else if (frm_we) begin
            frame_ff[row_sel] <= frame_ff[row_sel] ^ sprite_bits;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      hit_ff   <= hit_in;
      sts_ff   <= sts_in;
      rbyte_ff <= rbyte_in;
      row_ff   <= row_in;
      if (stk_we) stk_ff[push_idx] <= pc2;
      if (cmd.op == DP_CAPTURE) req_ff <= req_item;
      if (cmd.op == DP_FETCH_LO) op_hi_ff <= mem_rdata;
      if (cmd.op == DP_FETCH_OP) begin
         op_lo_ff <= mem_rdata;
         vx_ff    <= v_ff[op_hi_ff[3:0]];
      end
      if (cmd.op == DP_READ_VY) vy_ff <= v_ff[op_lo_ff[7:4]];
      if (cmd.op == DP_ISSUE) begin
         rsp_status     <= sts_ff;
         rsp_pc         <= pc_ff;
         rsp_read_byte  <= rbyte_ff;
         rsp_screen_row <= row_ff;
         rsp_sound_on   <= (sound_ff != 8'h00);
      end
   end

   `C8I_ASSERT_IMPL(a_sp_range, clock, reset, 1'b1, sp_ff <= SPW'(STACK_DEPTH))
   `C8I_ASSERT_NEXT(a_halt_sticky, clock, reset, halted_ff, halted_ff)
endmodule
`default_nettype wire

@@ rtl/c8i_ctrl.sv @@
// request sequencer and result handshake of the interpreter core
`default_nettype none
`include "chip8_interpreter_core_defines.svh"
module c8i_ctrl import c8i_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [2:0]    req_kind,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output cmd_type            cmd,
   input  wire dp_status_type dp_sts
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (dp_sts.clear_done) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_kind)
                  REQ_LOAD: state_in = ST_LOAD;
                  REQ_STEP: state_in = dp_sts.halted ? ST_REFUSE : ST_FETCH_HI;
                  REQ_TICK: state_in = ST_TICK;
                  REQ_KEY:  state_in = ST_KEY;
                  REQ_ROW:  state_in = ST_ROW;
                  REQ_READ: state_in = ST_RD_ADDR;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_LOAD, ST_TICK, ST_KEY, ST_ROW, ST_RD_CAP, ST_REFUSE: state_in = ST_DONE;
         ST_RD_ADDR:  state_in = ST_RD_CAP;
         ST_FETCH_HI: state_in = ST_FETCH_LO;
         ST_FETCH_LO: state_in = ST_FETCH_OP;
         ST_FETCH_OP: state_in = ST_READ_VY;
         ST_READ_VY:  state_in = ST_EXEC;
         ST_EXEC: begin
            case (dp_sts.cls)
               CLS_DRAW:  state_in = ST_DRAW_ADDR;
               CLS_BCD:   state_in = ST_BCD;
               CLS_STORE: state_in = ST_STORE;
               CLS_LOADV: state_in = ST_LV_ADDR;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_BCD:       if (dp_sts.bcd_last) state_in = ST_DONE;
         ST_STORE:     if (dp_sts.xfer_last) state_in = ST_DONE;
         ST_LV_ADDR:   state_in = ST_LV_CAP;
         ST_LV_CAP:    state_in = dp_sts.xfer_last ? ST_DONE : ST_LV_ADDR;
         ST_DRAW_ADDR: state_in = dp_sts.draw_more ? ST_DRAW_ROW : ST_DONE;
         ST_DRAW_ROW:  state_in = ST_DRAW_ADDR;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd.op = DP_IDLE;
      unique case (state_ff)
         ST_CLEAR:     cmd.op = DP_CLEAR;
         ST_IDLE:      if (req_tvalid) cmd.op = DP_CAPTURE;
         ST_LOAD:      cmd.op = DP_LOAD;
         ST_TICK:      cmd.op = DP_TICK;
         ST_KEY:       cmd.op = DP_KEY;
         ST_ROW:       cmd.op = DP_ROW;
         ST_RD_ADDR:   cmd.op = DP_RD_ADDR;
         ST_RD_CAP:    cmd.op = DP_RD_CAP;
         ST_REFUSE:    cmd.op = DP_REFUSE;
         ST_FETCH_HI:  cmd.op = DP_FETCH_HI;
         ST_FETCH_LO:  cmd.op = DP_FETCH_LO;
         ST_FETCH_OP:  cmd.op = DP_FETCH_OP;
         ST_READ_VY:   cmd.op = DP_READ_VY;
         ST_EXEC: begin
            cmd.op = (dp_sts.cls == CLS_UNKNOWN || dp_sts.cls == CLS_FAULT)
                     ? DP_FAULT : DP_EXEC;
         end
         ST_BCD:       cmd.op = DP_BCD;
         ST_STORE:     cmd.op = DP_STORE;
         ST_LV_ADDR:   cmd.op = DP_LV_ADDR;
         ST_LV_CAP:    cmd.op = DP_LV_CAP;
         ST_DRAW_ADDR: cmd.op = dp_sts.draw_more ? DP_DRAW_ADDR : DP_DRAW_END;
         ST_DRAW_ROW:  cmd.op = DP_DRAW_ROW;
         ST_DONE:      if (out_free) cmd.op = DP_ISSUE;
         default:      cmd.op = DP_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == DP_ISSUE) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `C8I_ASSERT_IMPL(a_no_accept_in_clear, clock, reset, state_ff == ST_CLEAR, !req_tready)
   `C8I_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_tvalid && req_tready,
                    state_ff != ST_IDLE)
   `C8I_ASSERT_IMPL(a_issue_into_free, clock, reset, cmd.op == DP_ISSUE, out_free)
endmodule
`default_nettype wire

@@ rtl/chip8_interpreter_core.sv @@
// top level of the chip-8 interpreter core
// read byte sets the address, then captures; step fetches, reads vy and executes; draw adds
// an address and a row state per sprite row, Fx55 a store state per register and Fx65 an
// address and a capture state per register; one item in work at a time through the shared
// memory port, the next taken once its result is issued; after reset the 4096-byte memory
// is swept one byte a cycle (font then zeros), no item taken; csr writes taken outside reset
`default_nettype none
module chip8_interpreter_core import c8i_pkg::*; #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [11:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // addr, data_byte, key_index, key_down, random_byte, row_index, zero pad
   input  wire logic [39:0] req_tdata,
   // req_type
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status, pc_out, read_byte, screen_row, sound_on, zero pad
   output logic [87:0]      rsp_tdata
);
   cmd_type       cmd;
   dp_status_type dp_sts;
   req_item_type  req_item;
   logic [1:0]    rsp_status;
   logic [11:0]   rsp_pc;
   logic [7:0]    rsp_read_byte;
   logic [63:0]   rsp_screen_row;
   logic          rsp_sound_on;

   assign req_item.addr        = req_tdata[11:0];
   assign req_item.data_byte   = req_tdata[19:12];
   assign req_item.key_index   = req_tdata[23:20];
   assign req_item.key_down    = req_tdata[24];
   assign req_item.random_byte = req_tdata[32:25];
   assign req_item.row_index   = req_tdata[37:33];

   assign rsp_tdata = {1'b0, rsp_sound_on, rsp_screen_row, rsp_read_byte, rsp_pc, rsp_status};

   c8i_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .dp_sts     (dp_sts)
   );

   c8i_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .dp_sts         (dp_sts),
      .req_item       (req_item),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_status     (rsp_status),
      .rsp_pc         (rsp_pc),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_screen_row (rsp_screen_row),
      .rsp_sound_on   (rsp_sound_on)
   );
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// self-checking stream testbench for the chip-8 interpreter core
module testbench;
   import c8i_pkg::*;

   localparam int STACK_LIMIT = 16;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [2:0]   kind;
      req_item_type f;
   } c8_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] pc;
      logic [7:0]  rbyte;
      logic [63:0] row;
      logic        snd;
   } c8_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [11:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;

   chip8_interpreter_core #(.STACK_DEPTH(STACK_LIMIT)) uut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #2 clock = ~clock;

   // shadow state of the core
   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  vreg [16];
   logic [15:0] ireg;
   logic [11:0] pc;
   logic [11:0] stk [STACK_LIMIT];
   int          sp;
   logic [7:0]  delay_cnt, sound_cnt;
   logic [15:0] keys;
   logic [63:0] frame [SCREEN_H];
   bit          halted;
   logic [11:0] start_addr;

   c8_req_type pending_reqs[$];
   c8_rsp_type expected_rsps[$];
   int send_idle = 0, recv_idle = 0;
   int errors = 0, n_rsp = 0, n_items = 0, n_steps = 0, stall = 0, hold_left = 0;
   bit hold_done = 0;
   c8_req_type drv_item;
   c8_rsp_type got, want;

   function automatic bit op_faults(logic [15:0] op);
      logic [7:0] kk;
      kk = op[7:0];
      case (op[15:12])
         4'h0: return !(op[11:0] == NNN_CLS || (op[11:0] == NNN_RET && sp != 0));
         4'h2: return sp >= STACK_LIMIT;
         4'h8: return !(op[3:0] <= 4'h7 || op[3:0] == 4'hE);
         4'hE: return !(kk == KK_SKP || kk == KK_SKNP);
         4'hF: return !(kk == KK_GDT || kk == KK_SDT || kk == KK_SST || kk == KK_ADDI ||
                        kk == KK_FONT || kk == KK_BCD || kk == KK_STOR || kk == KK_LOAD);
         default: return 0;
      endcase
   endfunction

   function automatic logic [1:0] run_op(logic [7:0] rnd);
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, f, vx, vy;
      logic [11:0] nxt;
      logic [63:0] bits;
      logic [8:0]  sum;
      int          i;
      op = {mem[pc], mem[pc + 12'd1]};
      x = op[11:8]; y = op[7:4]; n = op[3:0]; kk = op[7:0];
      nxt = pc + 12'd2;
      if (op_faults(op)) begin
         halted = 1;
         if (op[15:12] == 4'h2 || (op[15:12] == 4'h0 && op[11:0] == NNN_RET))
            return STS_FAULT;
         return STS_UNKNOWN;
      end
      vx = vreg[x]; vy = vreg[y];
      case (op[15:12])
         4'h0: if (op[11:0] == NNN_CLS) begin
               for (i = 0; i < SCREEN_H; i++) frame[i] = '0;
            end else begin
               sp--;
               nxt = stk[sp];
            end
         4'h1: nxt = op[11:0];
         4'h2: begin
            stk[sp] = nxt;
            sp++;
            nxt = op[11:0];
         end
         4'h3: if (vx == kk) nxt = nxt + 12'd2;
         4'h4: if (vx != kk) nxt = nxt + 12'd2;
         4'h5: if (vx == vy) nxt = nxt + 12'd2;
         4'h6: vreg[x] = kk;
         4'h7: vreg[x] = vx + kk;
         4'h8: case (n)
               4'h0: vreg[x] = vy;
               4'h1: vreg[x] = vx | vy;
               4'h2: vreg[x] = vx & vy;
               4'h3: vreg[x] = vx ^ vy;
               4'h4: begin
                  sum = vx + vy; vreg[x] = sum[7:0]; vreg[15] = {7'd0, sum[8]};
               end
               4'h5: begin f = {7'd0, vx >= vy}; vreg[x] = vx - vy; vreg[15] = f; end
               4'h6: begin f = {7'd0, vx[0]}; vreg[x] = vx >> 1; vreg[15] = f; end
               4'h7: begin f = {7'd0, vy >= vx}; vreg[x] = vy - vx; vreg[15] = f; end
               default: begin f = {7'd0, vx[7]}; vreg[x] = vx << 1; vreg[15] = f; end
            endcase
         4'h9: if (vx != vy) nxt = nxt + 12'd2;
         4'hA: ireg = {4'd0, op[11:0]};
         4'hB: nxt = {4'd0, vreg[0]} + op[11:0];
         4'hC: vreg[x] = rnd & kk;
         4'hD: begin
            f = 0;
            if (vx < SCREEN_W) begin
               for (i = 0; i < n && vy + i < SCREEN_H; i++) begin
                  bits = {mem[12'(ireg + i)], 56'd0} >> vx;
                  if ((frame[vy + i] & bits) != 0) f = 1;
                  frame[vy + i] ^= bits;
               end
            end
            vreg[15] = f;
         end
         4'hE: if (keys[vx[3:0]] == (kk == KK_SKP)) nxt = nxt + 12'd2;
         default: case (kk)
               KK_GDT:  vreg[x] = delay_cnt;
               KK_SDT:  delay_cnt = vx;
               KK_SST:  sound_cnt = vx;
               KK_ADDI: ireg = ireg + vx;
               KK_FONT: ireg = 16'(vx[3:0] * 5);
               KK_BCD: begin
                  mem[12'(ireg)]     = vx / 100;
                  mem[12'(ireg + 1)] = (vx % 100) / 10;
                  mem[12'(ireg + 2)] = vx % 10;
               end
               KK_STOR: for (i = 0; i <= x; i++) mem[12'(ireg + i)] = vreg[i];
               default: for (i = 0; i <= x; i++) vreg[i] = mem[12'(ireg + i)];
            endcase
      endcase
      pc = nxt;
      return STS_OK;
   endfunction

   function automatic c8_rsp_type c8_predict(c8_req_type it);
      c8_rsp_type r;
      r = '0;
      case (it.kind)
         REQ_LOAD: mem[it.f.addr] = it.f.data_byte;
         REQ_STEP: r.status = halted ? STS_HALTED : run_op(it.f.random_byte);
         REQ_TICK: begin
            if (delay_cnt != 0) delay_cnt--;
            if (sound_cnt != 0) sound_cnt--;
         end
         REQ_KEY:  keys[it.f.key_index] = it.f.key_down;
         REQ_ROW:  r.row = frame[it.f.row_index];
         REQ_READ: r.rbyte = mem[it.f.addr];
         default: ;
      endcase
      r.pc = pc;
      r.snd = sound_cnt != 0;
      return r;
   endfunction

   task automatic push_item(logic [2:0] kind, logic [11:0] addr, logic [7:0] dat,
                            logic [3:0] key, logic key_dn, logic [4:0] row);
      c8_req_type it;
      logic [63:0] r;
      r = {$urandom, $urandom};
      it.f = r[37:0];
      it.kind = kind;
      case (kind)
         REQ_LOAD, REQ_READ: begin it.f.addr = addr; it.f.data_byte = dat; end
         REQ_KEY: begin it.f.key_index = key; it.f.key_down = key_dn; end
         REQ_ROW: it.f.row_index = row;
         default: ;
      endcase
      if (kind == REQ_STEP) n_steps++;
      n_items++;
      expected_rsps.push_back(c8_predict(it));
      pending_reqs.push_back(it);
   endtask

   // place an instruction at the program counter, then execute it
   task automatic do_step(logic [15:0] op);
      push_item(REQ_LOAD, pc, op[15:8], 0, 0, 0);
      push_item(REQ_LOAD, pc + 12'd1, op[7:0], 0, 0, 0);
      push_item(REQ_STEP, 0, 0, 0, 0, 0);
   endtask

   function automatic logic [15:0] gen_op();
      logic [15:0] op;
      logic [7:0]  fk [8];
      fk = '{KK_GDT, KK_SDT, KK_SST, KK_ADDI, KK_FONT, KK_BCD, KK_STOR, KK_LOAD};
      op = 16'($urandom);
      case (op[15:12])
         4'h0: op[11:0] = $urandom_range(1) ? NNN_CLS : NNN_RET;
         4'h6: if ($urandom_range(1)) op[7:0] = $urandom_range(70);
         4'h8: if (op[3:0] >= 4'h8 && op[3:0] != 4'hE) op[3:0] = op[3:0] - 4'h8;
         4'hE: op[7:0] = $urandom_range(1) ? KK_SKP : KK_SKNP;
         4'hF: op[7:0] = fk[$urandom_range(7)];
         default: ;
      endcase
      if (op_faults(op)) op = (op[15:12] == 4'h2) ? {4'h1, op[11:0]} : {4'h0, NNN_CLS};
      return op;
   endfunction

   task automatic random_phase(int count);
      logic [15:0] op;
      int k, stop;
      stop = n_items + count;
      while (n_items < stop) begin
         k = $urandom_range(99);
         if (k < 60) begin
            op = {mem[pc], mem[pc + 12'd1]};
            if (op_faults(op) || $urandom_range(99) < 50) do_step(gen_op());
            else push_item(REQ_STEP, 0, 0, 0, 0, 0);
         end else if (k < 68) push_item(REQ_LOAD, 12'($urandom), 8'($urandom), 0, 0, 0);
         else if (k < 76) push_item(REQ_TICK, 0, 0, 0, 0, 0);
         else if (k < 84) push_item(REQ_KEY, 0, 0, 4'($urandom), 1'($urandom), 0);
         else if (k < 91) push_item(REQ_ROW, 0, 0, 0, 0, 5'($urandom));
         else if (k < 98) push_item(REQ_READ, 12'($urandom), 0, 0, 0, 0);
         else push_item(3'($urandom_range(7, 6)), 0, 0, 0, 0, 0);
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic csr_write(logic [11:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      start_addr = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
            drv_item = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, drv_item.f};
            req_tuser <= drv_item.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsp++;
         got.status = rsp_tdata[1:0];
         got.pc = rsp_tdata[13:2];
         got.rbyte = rsp_tdata[21:14];
         got.row = rsp_tdata[85:22];
         got.snd = rsp_tdata[86];
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item: %h", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch item %0d: status %0d/%0d pc %h/%h byte %h/%h row %h/%h snd %b/%b",
                           n_rsp, want.status, got.status, want.pc, got.pc, want.rbyte,
                           got.rbyte, want.row, got.row, want.snd, got.snd);
            end
         end
         if (n_rsp == 100 && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= recv_idle;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall = 0;
      else stall++;
      if (stall >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int i, kind;
      logic [11:0] nnn;
      logic [15:0] bad [4];
      for (i = 0; i < MEM_BYTES; i++) mem[i] = (i < FONT_LEN) ? FONT[i] : 8'h00;
      for (i = 0; i < 16; i++) vreg[i] = 0;
      for (i = 0; i < SCREEN_H; i++) frame[i] = 0;
      ireg = 0; pc = START_PC; sp = 0; delay_cnt = 0; sound_cnt = 0; keys = 0;
      halted = 0; start_addr = START_PC;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      csr_write(12'd0);

      // directed
      send_idle = 0; recv_idle = 0;
      push_item(REQ_LOAD, 12'hFFF, 8'hA5, 0, 0, 0);
      push_item(REQ_READ, 12'hFFF, 0, 0, 0, 0);
      push_item(REQ_READ, 12'h000, 0, 0, 0, 0);
      push_item(REQ_READ, 12'd79, 0, 0, 0, 0);
      push_item(REQ_KEY, 0, 0, 4'h0, 1, 0);
      push_item(REQ_KEY, 0, 0, 4'hF, 1, 0);
      push_item(REQ_KEY, 0, 0, 4'hF, 0, 0);
      push_item(REQ_TICK, 0, 0, 0, 0, 0);
      push_item(3'd6, 0, 0, 0, 0, 0);
      push_item(3'd7, 0, 0, 0, 0, 0);
      do_step(16'h60FF);
      do_step(16'hF018);
      do_step(16'h8004);
      do_step(16'hA000);
      do_step(16'hD115);
      push_item(REQ_ROW, 0, 0, 0, 0, 5'd0);
      do_step(16'hD115);
      push_item(REQ_ROW, 0, 0, 0, 0, 5'd31);
      drain();

      send_idle = 34; recv_idle = 87;
      random_phase(570);
      drain();
      csr_write(12'hFFF);
      send_idle = 87; recv_idle = 34;
      random_phase(570);
      drain();
      csr_write(12'($urandom));
      send_idle = 0; recv_idle = 0;
      random_phase(570);
      drain();
      csr_write(START_PC);

      // the core halts only once, so one way of halting is picked per run
      kind = $urandom_range(2);
      nnn = 12'($urandom);
      if (nnn == NNN_CLS || nnn == NNN_RET) nnn = 12'h000;
      bad = '{{4'h0, nnn}, {4'h8, 8'($urandom), 4'h8}, 16'hE000, 16'hF00A};
      if (kind == 0) begin
         do_step(bad[$urandom_range(3)]);
      end else if (kind == 1) begin
         while (sp < STACK_LIMIT) do_step({4'h2, 12'($urandom)});
         do_step({4'h2, 12'($urandom)});
      end else begin
         while (sp > 0) do_step({4'h0, NNN_RET});
         do_step({4'h0, NNN_RET});
      end
      push_item(REQ_STEP, 0, 0, 0, 0, 0);
      push_item(REQ_TICK, 0, 0, 0, 0, 0);
      push_item(REQ_READ, pc, 0, 0, 0, 0);
      push_item(REQ_STEP, 0, 0, 0, 0, 0);
      drain();

      $display("covered %0d items (%0d steps), %0d results, halting kind %0d",
               n_items, n_steps, n_rsp, kind);
      $display("idle mixes 34/87, 87/34 and none, one long receiver hold-off");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
